>>> src/k4_through_vertex_detector_core_macros.svh
// Assertion macros shared by the four-clique detector modules.
`ifndef K4_THROUGH_VERTEX_DETECTOR_CORE_MACROS_SVH
`define K4_THROUGH_VERTEX_DETECTOR_CORE_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define K4TV_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("k4tv invariant violated");

// A trigger that must be followed by a consequence in the next cycle.
`define K4TV_ASSERT_NEXT(label, clk, rst, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("k4tv sequence violated");

`endif

>>> src/k4tv_pkg.sv
// Types and constants shared by the four-clique detector modules.
package k4tv_pkg;

  localparam int OPCODE_W = 2;
  localparam int VERTEX_W = 3;

  typedef logic [VERTEX_W-1:0] vertex_t;

  typedef enum logic [OPCODE_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_QUERY  = 2'd2
  } opcode_t;

  typedef struct packed {
    logic    clear;
    logic    insert;
    logic    directed;
    vertex_t vertex_a;
    vertex_t vertex_b;
  } store_cmd_t;

endpackage

>>> src/k4tv_store.sv
// Adjacency and directed-mark matrices with insert and clear updates.
`include "k4_through_vertex_detector_core_macros.svh"

module k4tv_store
  import k4tv_pkg::*;
#(
  parameter int VERTEX_COUNT = 8
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  store_cmd_t                                     cmd,
  output logic [VERTEX_COUNT-1:0][VERTEX_COUNT-1:0]      adjacency,
  output logic [VERTEX_COUNT-1:0][VERTEX_COUNT-1:0]      directed
);

  localparam int IdxW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;

  logic [IdxW-1:0] idx_a;
  logic [IdxW-1:0] idx_b;
  logic [VERTEX_COUNT-1:0][VERTEX_COUNT-1:0] adjacency_t;

  assign idx_a = IdxW'(cmd.vertex_a);
  assign idx_b = IdxW'(cmd.vertex_b);

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      adjacency <= '0;
      directed  <= '0;
    end else if (cmd.insert) begin
      adjacency[idx_a][idx_b] <= 1'b1;
      adjacency[idx_b][idx_a] <= 1'b1;
      directed[idx_a][idx_b]  <= cmd.directed;
      directed[idx_b][idx_a]  <= cmd.directed;
    end
  end

  always_comb begin
    for (int u = 0; u < VERTEX_COUNT; u++) begin
      for (int w = 0; w < VERTEX_COUNT; w++) begin
        adjacency_t[u][w] = adjacency[w][u];
      end
    end
  end

  // The graph is undirected in storage, and a directed mark needs an edge under it.
  `K4TV_ASSERT_ALWAYS(a_adjacency_symmetric, clk, rst, adjacency_t == adjacency)
  `K4TV_ASSERT_ALWAYS(a_directed_on_edge, clk, rst, (directed & ~adjacency) == '0)
  `K4TV_ASSERT_NEXT(a_clear_empties, clk, rst, cmd.clear,
                    (adjacency == '0) && (directed == '0))

endmodule

>>> src/k4tv_search.sv
// Parallel check of every vertex triple for a four-clique through the queried vertex with a directed edge.
module k4tv_search
  import k4tv_pkg::*;
#(
  parameter int VERTEX_COUNT = 8
) (
  input  logic [VERTEX_COUNT-1:0][VERTEX_COUNT-1:0] adjacency,
  input  logic [VERTEX_COUNT-1:0][VERTEX_COUNT-1:0] directed,
  input  vertex_t                                   query_vertex,
  output logic                                      found
);

  localparam int IdxW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;

  logic [IdxW-1:0]         idx_q;
  logic [VERTEX_COUNT-1:0] nb;
  logic [VERTEX_COUNT-1:0] vdir;

  assign idx_q = IdxW'(query_vertex);
  assign nb    = adjacency[idx_q];
  assign vdir  = directed[idx_q];

  // The query vertex has no self-loop, so triples that contain it never match.
  always_comb begin
    found = 1'b0;
    for (int i = 0; i < VERTEX_COUNT; i++) begin
      for (int j = i + 1; j < VERTEX_COUNT; j++) begin
        for (int k = j + 1; k < VERTEX_COUNT; k++) begin
          if (nb[i] && nb[j] && nb[k] &&
              adjacency[i][j] && adjacency[j][k] && adjacency[k][i] &&
              (vdir[i] || vdir[j] || vdir[k] ||
               directed[i][j] || directed[j][k] || directed[k][i])) begin
            found = 1'b1;
          end
        end
      end
    end
  end

endmodule

>>> src/k4_through_vertex_detector_core.sv
// Top level of the four-vertex clique detector with input and result registers.
// A query item passes through the stage register and then the result register.
// Throughput: one item per cycle unless a query stalls; the clique search is combinational.
// Clear and insert items update the matrices and give no result.
// Reset is synchronous and clears both matrices and all valid flags.
`include "k4_through_vertex_detector_core_macros.svh"

module k4_through_vertex_detector_core
  import k4tv_pkg::*;
#(
  parameter int VERTEX_COUNT = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic [OPCODE_W-1:0] opcode,
  input  logic [VERTEX_W-1:0] vertex_a,
  input  logic [VERTEX_W-1:0] vertex_b,
  input  logic                edge_directed,
  input  logic [VERTEX_W-1:0] query_vertex,
  output logic                result_valid,
  input  logic                result_stall,
  output logic                contains_clique
);

  localparam logic [4:0] VcLimit = 5'(VERTEX_COUNT);

  logic                stage_valid;
  logic [OPCODE_W-1:0] stage_opcode;
  vertex_t             stage_a;
  vertex_t             stage_b;
  logic                stage_directed;
  vertex_t             stage_query;

  logic       stage_is_query;
  logic       stage_is_clear;
  logic       stage_is_insert;
  logic       result_free;
  logic       advance;
  logic       edge_ok;
  logic       query_ok;
  logic       found;
  store_cmd_t cmd;

  logic [VERTEX_COUNT-1:0][VERTEX_COUNT-1:0] adjacency;
  logic [VERTEX_COUNT-1:0][VERTEX_COUNT-1:0] directed;

  always_comb begin
    stage_is_query  = 1'b0;
    stage_is_clear  = 1'b0;
    stage_is_insert = 1'b0;
    unique case (opcode_t'(stage_opcode))
      OP_CLEAR:  stage_is_clear  = 1'b1;
      OP_INSERT: stage_is_insert = 1'b1;
      OP_QUERY:  stage_is_query  = 1'b1;
      default:   ;
    endcase
  end

  assign result_free = !result_valid || !result_stall;
  assign advance     = !stage_valid || !stage_is_query || result_free;
  assign item_stall  = !advance;

  assign edge_ok = (stage_a != stage_b) &&
                   ({2'b00, stage_a} < VcLimit) && ({2'b00, stage_b} < VcLimit);
  assign query_ok = ({2'b00, stage_query} < VcLimit);

  always_comb begin
    cmd.clear    = stage_valid && stage_is_clear;
    cmd.insert   = stage_valid && stage_is_insert && edge_ok;
    cmd.directed = stage_directed;
    cmd.vertex_a = stage_a;
    cmd.vertex_b = stage_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (advance) begin
      stage_valid <= item_valid;
    end
    if (advance && item_valid) begin
      stage_opcode   <= opcode;
      stage_a        <= vertex_a;
      stage_b        <= vertex_b;
      stage_directed <= edge_directed;
      stage_query    <= query_vertex;
    end
  end

  k4tv_store #(
    .VERTEX_COUNT(VERTEX_COUNT)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .adjacency (adjacency),
    .directed  (directed)
  );

  k4tv_search #(
    .VERTEX_COUNT(VERTEX_COUNT)
  ) u_search (
    .adjacency    (adjacency),
    .directed     (directed),
    .query_vertex (stage_query),
    .found        (found)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_free) begin
      result_valid <= stage_valid && stage_is_query;
    end
    if (result_free && stage_valid && stage_is_query) begin
      contains_clique <= query_ok && found;
    end
  end

  // A query that leaves the stage must appear as a result, and a stalled stage keeps its item.
  `K4TV_ASSERT_NEXT(a_query_reaches_result, clk, rst,
                    stage_valid && stage_is_query && advance, result_valid)
  `K4TV_ASSERT_NEXT(a_stall_keeps_item, clk, rst, item_stall,
                    stage_valid && stage_is_query)
  `K4TV_ASSERT_ALWAYS(a_stall_only_when_full, clk, rst,
                      !item_stall || (result_valid && result_stall))

endmodule
